/* src/sfir_pkg.sv */
// ----------------------------------------------------------------------------
// Stereo FIR filter package
// Shared widths, types and constants of the stereo FIR filter core.
// ----------------------------------------------------------------------------
package sfir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int NCOEF      = 8;
    localparam int TAPS       = 8;
    localparam int HDEPTH     = NCOEF - 1;
    localparam int TAP_W      = $clog2(NCOEF);
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + TAP_W + 1;
    localparam int FRAC_BITS  = 15;
    localparam int DATA_W     = 2 * SAMPLE_W;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = TAP_W + 2;

    typedef logic signed [SAMPLE_W-1:0]     sample_t;
    typedef logic signed [COEF_W-1:0]       coef_t;
    typedef logic [NCOEF-1:0][COEF_W-1:0]   coef_arr_t;
    typedef logic [TAP_W-1:0]               tap_idx_t;

    localparam coef_t COEF0_RESET = 16'sh7FFF;

    localparam logic CHAN_LEFT  = 1'b0;
    localparam logic CHAN_RIGHT = 1'b1;

    // One multiply-accumulate operation issued to the shared unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic chan;
    } mac_ctl_t;

    // Finished sum of one channel, already scaled and saturated.
    typedef struct packed {
        logic    done;
        logic    chan;
        sample_t value;
    } mac_res_t;

endpackage

/* src/sfir_regs.sv */
// ----------------------------------------------------------------------------
// Coefficient register file
// APB-style write/read port holding the eight Q1.15 coefficients.
// ----------------------------------------------------------------------------
module sfir_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfir_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sfir_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sfir_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output sfir_pkg::coef_arr_t              coef
);
    import sfir_pkg::*;

    coef_arr_t coef_reg;
    tap_idx_t  reg_idx;
    logic      wr_en;
    coef_t     rd_coef;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    // Reset leaves only the newest-sample tap at its near-unity value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= {{((NCOEF-1)*COEF_W){1'b0}}, COEF0_RESET};
        end else if (wr_en) begin
            coef_reg[reg_idx] <= pwdata[COEF_W-1:0];
        end
    end

    // Reads return the coefficient sign-extended to the bus width.
    assign rd_coef = coef_reg[reg_idx];
    assign prdata  = {{(APB_DATA_W-COEF_W){rd_coef[COEF_W-1]}}, rd_coef};
    assign coef    = coef_reg;

endmodule

/* src/sfir_mac.sv */
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered 16x16 multiplier, wide accumulator and Q1.15 output scaling.
// ----------------------------------------------------------------------------
module sfir_mac (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfir_pkg::mac_ctl_t  ctl,
    input  sfir_pkg::coef_t     coef,
    input  sfir_pkg::sample_t   sample,
    output sfir_pkg::mac_res_t  res
);
    import sfir_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2**FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(2**(SAMPLE_W-1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN    = ACC_W'(-(2**(SAMPLE_W-1)));

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    mac_ctl_t                 pctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;
    logic                     chan_reg;
    logic signed [ACC_W-1:0]  bias;
    logic signed [ACC_W-1:0]  adj;
    logic signed [ACC_W-1:0]  quot;
    sample_t                  sat_val;

    assign prod_next = PROD_W'(coef * sample);
    assign acc_next  = pctl_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pctl_reg <= '0;
            done_reg <= 1'b0;
            chan_reg <= CHAN_LEFT;
        end else begin
            pctl_reg <= ctl;
            done_reg <= pctl_reg.valid && pctl_reg.last;
            chan_reg <= pctl_reg.chan;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.valid) begin
            prod_reg <= prod_next;
        end
        if (pctl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    // Divide by 2^15 toward zero: negative sums get a bias before the shift.
    assign bias = acc_reg[ACC_W-1] ? ROUND_BIAS : '0;
    assign adj  = acc_reg + bias;
    assign quot = adj >>> FRAC_BITS;

    always_comb begin
        priority if (quot > SAT_MAX) begin
            sat_val = SAT_MAX[SAMPLE_W-1:0];
        end else if (quot < SAT_MIN) begin
            sat_val = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            sat_val = quot[SAMPLE_W-1:0];
        end
    end

    assign res.done  = done_reg;
    assign res.chan  = chan_reg;
    assign res.value = sat_val;

endmodule

/* src/stereo_fir_filter_core.sv */
// ----------------------------------------------------------------------------
// Stereo FIR filter core
// Eight-tap direct-form FIR on a stereo stream, one shared MAC for both sides.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one stereo beat per item: s_tdata[15:0] is the left
// sample and s_tdata[31:16] the right sample, both signed 16-bit PCM. The
// master stream returns one filtered beat per item with the same packing.
// Coefficients coef_0..coef_7 (Q1.15) sit on the APB port at byte address
// 4*i; they must be written only while the core is idle, which the core
// itself does not enforce. Timing: after a beat is accepted, the shared
// multiply-accumulate unit runs TAPS operations for the left channel and
// then TAPS for the right, one per cycle, followed by a drain of the
// multiplier and accumulator registers and a load of the output register.
// s_tready is high only while idle, so no new beat is accepted until the
// last result has been loaded into the output register; the throughput is
// set by the single shared MAC.
// Reset (aresetn low, synchronous) restores coef_0 to 32767, clears the other
// coefficients and both delay lines, and empties the output register.
// If the receiver stalls, the finished result waits in the output register.
// The next beat is still taken and computed, but its result then waits in the
// core, and no further beat is accepted until the output register is taken.
// ----------------------------------------------------------------------------
module stereo_fir_filter_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Slave stream: [15:0] left_in, [31:16] right_in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sfir_pkg::DATA_W-1:0]      s_tdata,
    // Master stream: [15:0] left_out, [31:16] right_out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sfir_pkg::DATA_W-1:0]      m_tdata,
    // Coefficient configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfir_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sfir_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sfir_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import sfir_pkg::*;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    tap_idx_t    tap_reg;
    tap_idx_t    tap_next;
    logic        chan_reg;
    logic        chan_next;

    sample_t     new_l_reg;
    sample_t     new_r_reg;
    sample_t     hist_l_reg [HDEPTH];
    sample_t     hist_r_reg [HDEPTH];
    sample_t     res_l_reg;
    sample_t     res_r_reg;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;

    coef_arr_t   coef_arr;
    mac_ctl_t    mac_ctl;
    mac_res_t    mac_res;
    sample_t     mac_sample;
    coef_t       mac_coef;
    tap_idx_t    hist_idx;
    logic        last_tap;
    logic        s_accept;
    logic        load_out;

    sfir_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef_arr)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
    assign last_tap = (tap_reg == TAP_W'(TAPS - 1));

    // Operand selection for the shared MAC: tap zero uses the sample of the
    // current beat, later taps read the channel's delay line one place back.
    assign hist_idx   = tap_reg - TAP_W'(1);
    assign mac_coef   = coef_arr[tap_reg];

    always_comb begin
        if (tap_reg == '0) begin
            mac_sample = (chan_reg == CHAN_RIGHT) ? new_r_reg : new_l_reg;
        end else begin
            mac_sample = (chan_reg == CHAN_RIGHT) ? hist_r_reg[hist_idx]
                                                  : hist_l_reg[hist_idx];
        end
    end

    assign mac_ctl.valid = (state_reg == ST_RUN);
    assign mac_ctl.first = (tap_reg == '0);
    assign mac_ctl.last  = last_tap;
    assign mac_ctl.chan  = chan_reg;

    sfir_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .coef    (mac_coef),
        .sample  (mac_sample),
        .res     (mac_res)
    );

    // Sequencer: walk the taps of the left channel, then the right channel.
    always_comb begin
        state_next = state_reg;
        tap_next   = tap_reg;
        chan_next  = chan_reg;
        unique case (state_reg)
            ST_IDLE: begin
                tap_next  = '0;
                chan_next = CHAN_LEFT;
                if (s_accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_tap) begin
                    tap_next = '0;
                    if (chan_reg == CHAN_RIGHT) begin
                        state_next = ST_DRAIN;
                    end else begin
                        chan_next = CHAN_RIGHT;
                    end
                end else begin
                    tap_next = tap_reg + TAP_W'(1);
                end
            end
            ST_DRAIN: begin
                if (mac_res.done && mac_res.chan == CHAN_RIGHT) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_reg     <= '0;
            chan_reg    <= CHAN_LEFT;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < HDEPTH; i++) begin
                hist_l_reg[i] <= '0;
                hist_r_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            chan_reg  <= chan_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            // The delay lines age by one place when the result is loaded into the output register.
            if (load_out) begin
                hist_l_reg[0] <= new_l_reg;
                hist_r_reg[0] <= new_r_reg;
                for (int i = 1; i < HDEPTH; i++) begin
                    hist_l_reg[i] <= hist_l_reg[i-1];
                    hist_r_reg[i] <= hist_r_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            new_l_reg <= s_tdata[SAMPLE_W-1:0];
            new_r_reg <= s_tdata[DATA_W-1:SAMPLE_W];
        end
        if (mac_res.done) begin
            if (mac_res.chan == CHAN_RIGHT) begin
                res_r_reg <= mac_res.value;
            end else begin
                res_l_reg <= mac_res.value;
            end
        end
        if (load_out) begin
            m_data_reg <= {res_r_reg, res_l_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // An accepted beat always starts the tap walk on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_RUN && tap_reg == '0 && chan_reg == CHAN_LEFT))
        else $error("tap walk did not start after an accepted beat");

    // The MAC never reports a finished sum while the core is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mac_res.done)
        else $error("MAC result while idle");

    // The right channel sum completes only while the sequencer drains.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mac_res.done && mac_res.chan == CHAN_RIGHT) |-> (state_reg == ST_DRAIN))
        else $error("right channel sum outside the drain state");
`endif

endmodule
